// ----- hw/rtl/fspe_pkg.sv -----
// Package for the format string print engine: character codes, weight and
// hex digit functions, and the command and status structs between
// controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fspe_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned NUM_WTS = 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  // Source of the character written into the output register.
  typedef enum logic [2:0] {
    EM_INCHAR,
    EM_PCT,
    EM_ARGLO,
    EM_MINUS,
    EM_DIGIT,
    EM_ONES,
    EM_HEX
  } emit_sel_t;

  typedef struct packed {
    logic      emit;
    emit_sel_t sel;
    logic      last;
    logic      taken;
    logic      load_word;
    logic      neg_word;
    logic      sub;
    logic      next_digit;
    logic      hex_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic ge;
    logic digit_nz;
    logic started;
    logic widx_done;
    logic hex_done;
  } dp_stat_t;

  // Decimal place weights, highest first.
  function automatic logic [WORD_W-1:0] dec_weight(input logic [1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      2'd0:    w = 16'd10000;
      2'd1:    w = 16'd1000;
      2'd2:    w = 16'd100;
      default: w = 16'd10;
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 4'd10) c = CH_ZERO + {4'd0, v};
    else           c = CH_UPPER_A + {4'd0, v} - 8'd10;
    return c;
  endfunction

endpackage

// ----- hw/rtl/fspe_ctrl.sv -----
// Controller of the format string print engine: pending-percent flag and
// the state machine that sequences conversions. Uses fspe_pkg.
`timescale 1ns / 1ps

module fspe_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [fspe_pkg::CHAR_W-1:0]    fmt_char,
  input  logic                           arg_neg,
  output logic                           in_ready,
  input  fspe_pkg::dp_stat_t             stat,
  output fspe_pkg::dp_cmd_t              cmd
);
  import fspe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_HEX
  } state_t;

  state_t state_r, state_nxt;
  logic   pending_r, pending_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && stat.slot_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    cmd         = '0;
    cmd.sel     = EM_INCHAR;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_word = 1'b1;
          if (!pending_r) begin
            if (fmt_char == CH_PCT) begin
              pending_nxt = 1'b1;
            end else if (fmt_char != CH_NUL) begin
              cmd.emit = 1'b1;
              cmd.sel  = EM_INCHAR;
              cmd.last = 1'b1;
            end
          end else begin
            pending_nxt = 1'b0;
            if (fmt_char == CH_PCT) begin
              cmd.emit = 1'b1;
              cmd.sel  = EM_PCT;
              cmd.last = 1'b1;
            end else if (fmt_char == CH_C) begin
              cmd.emit  = 1'b1;
              cmd.sel   = EM_ARGLO;
              cmd.last  = 1'b1;
              cmd.taken = 1'b1;
            end else if (fmt_char inside {CH_D, CH_I}) begin
              if (arg_neg) begin
                cmd.emit     = 1'b1;
                cmd.sel      = EM_MINUS;
                cmd.taken    = 1'b1;
                cmd.neg_word = 1'b1;
              end
              state_nxt = S_DEC;
            end else if (fmt_char == CH_U) begin
              state_nxt = S_DEC;
            end else if (fmt_char == CH_X) begin
              state_nxt = S_HEX;
            end
          end
        end
      end
      S_DEC: begin
        if (stat.widx_done) begin
          if (stat.slot_free) begin
            cmd.emit  = 1'b1;
            cmd.sel   = EM_ONES;
            cmd.last  = 1'b1;
            cmd.taken = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (stat.ge) begin
          cmd.sub = 1'b1;
        end else if (stat.started || stat.digit_nz) begin
          if (stat.slot_free) begin
            cmd.emit       = 1'b1;
            cmd.sel        = EM_DIGIT;
            cmd.taken      = 1'b1;
            cmd.next_digit = 1'b1;
          end
        end else begin
          cmd.next_digit = 1'b1;
        end
      end
      S_HEX: begin
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = EM_HEX;
          cmd.taken     = 1'b1;
          cmd.last      = stat.hex_done;
          cmd.hex_shift = 1'b1;
          if (stat.hex_done) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pending_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ----- hw/rtl/fspe_dp.sv -----
// Datapath of the format string print engine: working word, decimal digit
// counter, hex position and the output register. Uses fspe_pkg.
`timescale 1ns / 1ps

module fspe_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fspe_pkg::CHAR_W-1:0]    fmt_char,
  input  logic [fspe_pkg::WORD_W-1:0]    arg_word,
  input  fspe_pkg::dp_cmd_t              cmd,
  output fspe_pkg::dp_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fspe_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_last,
  output logic                           out_taken
);
  import fspe_pkg::*;

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [2:0]        widx_r, widx_nxt;
  logic              started_r, started_nxt;
  logic [1:0]        hidx_r, hidx_nxt;
  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, taken_r;
  logic [WORD_W-1:0] weight;

  assign weight = dec_weight(widx_r[1:0]);

  assign stat.slot_free = !valid_r || out_ready;
  assign stat.ge        = (word_r >= weight);
  assign stat.digit_nz  = (cnt_r != 4'd0);
  assign stat.started   = started_r;
  assign stat.widx_done = (widx_r == 3'(NUM_WTS));
  assign stat.hex_done  = (hidx_r == 2'd0);

  always_comb begin
    word_nxt    = word_r;
    cnt_nxt     = cnt_r;
    widx_nxt    = widx_r;
    started_nxt = started_r;
    hidx_nxt    = hidx_r;
    if (cmd.load_word) begin
      // Two's complement negate gives the exact magnitude, 0x8000 included.
      word_nxt    = cmd.neg_word ? (~arg_word + 16'd1) : arg_word;
      cnt_nxt     = 4'd0;
      widx_nxt    = 3'd0;
      started_nxt = 1'b0;
      hidx_nxt    = 2'd3;
    end
    if (cmd.sub) begin
      word_nxt = word_r - weight;
      cnt_nxt  = cnt_r + 4'd1;
    end
    if (cmd.next_digit) begin
      widx_nxt    = widx_r + 3'd1;
      cnt_nxt     = 4'd0;
      started_nxt = started_r | cmd.emit;
    end
    if (cmd.hex_shift) begin
      word_nxt = {word_r[WORD_W-5:0], 4'd0};
      hidx_nxt = hidx_r - 2'd1;
    end
  end

  always_comb begin
    case (cmd.sel)
      EM_INCHAR: char_nxt = fmt_char;
      EM_PCT:    char_nxt = CH_PCT;
      EM_ARGLO:  char_nxt = arg_word[CHAR_W-1:0];
      EM_MINUS:  char_nxt = CH_MINUS;
      EM_DIGIT:  char_nxt = CH_ZERO + {4'd0, cnt_r};
      EM_ONES:   char_nxt = CH_ZERO + {4'd0, word_r[3:0]};
      EM_HEX:    char_nxt = hex_char(word_r[WORD_W-1:WORD_W-4]);
      default:   char_nxt = CH_NUL;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.emit)                valid_nxt = 1'b1;
    else if (valid_r && out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    cnt_r     <= cnt_nxt;
    widx_r    <= widx_nxt;
    started_r <= started_nxt;
    hidx_r    <= hidx_nxt;
    if (cmd.emit) begin
      char_r  <= char_nxt;
      last_r  <= cmd.last;
      taken_r <= cmd.taken;
    end
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_taken = taken_r;

endmodule

// ----- hw/rtl/format_string_print_engine_unit.sv -----
// Top level of the format string print engine: stream ports around the
// controller (fspe_ctrl) and the datapath (fspe_dp). Uses fspe_pkg.
`timescale 1ns / 1ps

//  Channel  | Direction | tdata                         | tlast     | tuser
//  ---------+-----------+-------------------------------+-----------+----------
//  in_      | input     | [7:0] fmt_char, [23:8] arg    | -         | -
//  out_     | output    | [7:0] out_char                | last      | arg_taken
//
// One item is taken at a time. A plain character, %%, %c and an item that
// emits nothing are done with on acceptance; %x then emits its four hex digits
// one by one, highest first. For %d, %i and %u the digits come from a single
// subtractor that removes one place weight per cycle, plus one step for each
// of the four upper places (a digit or a suppressed zero) and one for the ones
// digit. Reset (rst_n low, synchronous) clears the pending-percent flag, the
// state machine and the output valid. A stalled output holds its item in the
// output register; the block keeps working until it needs that register
// again, and the next input item is accepted only when the output register
// is empty or is being read in that same cycle.

module format_string_print_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] fmt_char, [23:8] arg_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] arg_taken
);
  import fspe_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [CHAR_W-1:0] fmt_char;
  logic [WORD_W-1:0] arg_word;
  logic              taken;

  assign fmt_char = in_tdata[CHAR_W-1:0];
  assign arg_word = in_tdata[CHAR_W+WORD_W-1:CHAR_W];

  // The controller only needs the sign of the argument for %d and %i.
  fspe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .fmt_char (fmt_char),
    .arg_neg  (arg_word[WORD_W-1]),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fspe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt_char  (fmt_char),
    .arg_word  (arg_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_taken (taken)
  );

  assign out_tuser = taken;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for format_string_print_engine_unit: a directed table followed by
// random format strings, checked against a behavioral predictor of the engine.
// Depends on fspe_pkg and the RTL of the engine only.
`timescale 1ns / 1ps

module tb;
  import fspe_pkg::*;

  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned RANDOM_ITEMS = 285;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HANG_LIMIT   = 3000;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_ROWS     = 25;

  // A conversion character that the engine does not know.
  localparam logic [CHAR_W-1:0] CH_BOGUS = "z";

  // One output character as the result channel carries it.
  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
    logic              taken;
  } glyph_t;

  // One row of the directed table. Where typed is set, the expected output is
  // written in the row itself: n characters in txt, the first one highest.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [WORD_W-1:0] arg;
    logic              typed;
    logic [2:0]        n;
    logic              taken;
    logic [47:0]       txt;
  } row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  // Predictor state: a percent sign waiting for its conversion character.
  logic   pct_armed = 1'b0;
  // Characters the engine still owes, oldest first.
  glyph_t owed_glyphs [$];

  int unsigned mismatches   = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bit          hold_off_req = 1'b0;

  row_t directed_rows [NUM_ROWS] = '{
    '{"A",      16'h0000, 1'b1, 3'd1, 1'b0, "A"},      // first item after reset
    '{CH_NUL,   16'hFFFF, 1'b1, 3'd0, 1'b0, 48'h0},    // end of string while idle
    '{8'hFF,    16'hFFFF, 1'b1, 3'd1, 1'b0, 48'hFF},   // highest plain character
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_PCT,   16'hFFFF, 1'b1, 3'd1, 1'b0, "%"},      // literal percent
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_C,     16'hFFFF, 1'b1, 3'd1, 1'b1, 48'hFF},
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_D,     16'h8000, 1'b1, 3'd6, 1'b1, "-32768"}, // most negative value
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_I,     16'h7FFF, 1'b1, 3'd5, 1'b1, "32767"},
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_U,     16'hFFFF, 1'b1, 3'd5, 1'b1, "65535"},
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_U,     16'h0000, 1'b1, 3'd1, 1'b1, "0"},
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_X,     16'hA5C3, 1'b1, 3'd4, 1'b1, "A5C3"},
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_D,     16'hFFFF, 1'b1, 3'd2, 1'b1, "-1"},
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_NUL,   16'h1234, 1'b1, 3'd0, 1'b0, 48'h0},    // end of string after a percent
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_BOGUS, 16'hFFFF, 1'b1, 3'd0, 1'b0, 48'h0},    // unknown conversion
    '{CH_PCT,   16'h0000, 1'b1, 3'd0, 1'b0, 48'h0},
    '{CH_I,     16'hD8F1, 1'b0, 3'd0, 1'b0, 48'h0}     // checked by the predictor
  };

  // Arguments that sit on the borders of the decimal and signed ranges.
  logic [WORD_W-1:0] border_args [14] = '{
    16'h0000, 16'h0001, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
    16'd9999, 16'd10000, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF
  };

  format_string_print_engine_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Idle stretches: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Works out the characters one format character produces and advances the
  // pending-percent state. Decimal digits come from division by the place
  // weights; leading zeros are dropped, but the ones digit always appears.
  function automatic int unsigned format_char(input logic [CHAR_W-1:0] c,
                                              input logic [WORD_W-1:0] w,
                                              output logic [5:0][7:0] chars,
                                              output logic taken);
    int unsigned n;
    int unsigned mag;
    int unsigned cnt;
    logic        lead;
    logic [3:0]  nib;
    int unsigned places [4];
    places = '{10000, 1000, 100, 10};
    n      = 0;
    taken  = 1'b0;
    chars  = '0;
    if (!pct_armed) begin
      if (c == CH_PCT) begin
        pct_armed = 1'b1;
      end else if (c != CH_NUL) begin
        chars[0] = c;
        n = 1;
      end
    end else begin
      pct_armed = 1'b0;
      case (c)
        CH_PCT: begin
          chars[0] = CH_PCT;
          n = 1;
        end
        CH_C: begin
          chars[0] = w[7:0];
          taken = 1'b1;
          n = 1;
        end
        CH_D, CH_I, CH_U: begin
          taken = 1'b1;
          mag = w;
          if (c != CH_U && w[15]) begin
            chars[n] = CH_MINUS;
            n++;
            mag = 32'h10000 - w;
          end
          lead = 1'b0;
          for (int k = 0; k < 4; k++) begin
            cnt = mag / places[k];
            mag = mag % places[k];
            if (lead || cnt != 0) begin
              chars[n] = CH_ZERO + 8'(cnt);
              n++;
              lead = 1'b1;
            end
          end
          chars[n] = CH_ZERO + 8'(mag);
          n++;
        end
        CH_X: begin
          taken = 1'b1;
          for (int k = 0; k < 4; k++) begin
            nib = w[4*(3-k) +: 4];
            chars[k] = (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_UPPER_A + 8'(nib) - 8'd10;
          end
          n = 4;
        end
        default: ;
      endcase
    end
    return n;
  endfunction

  // Offers one item, after an optional idle gap, and returns once it has been
  // accepted. The expected characters are queued at the acceptance edge; a
  // typed row supplies its own, the predictor only keeps its state in step.
  task automatic send_item(input row_t row);
    int unsigned      gap;
    int unsigned      n;
    logic [5:0][7:0]  chars;
    logic             taken;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.arg, row.ch};
    do @(posedge clk); while (!in_tready);
    n = format_char(row.ch, row.arg, chars, taken);
    if (row.typed) begin
      for (int i = 0; i < row.n; i++)
        owed_glyphs.push_back('{row.txt[8*(row.n-1-i) +: 8], i == row.n - 1, row.taken});
    end else begin
      for (int i = 0; i < n; i++)
        owed_glyphs.push_back('{chars[i], i == n - 1, taken});
    end
  endtask

  // Lowers valid and waits until the engine has delivered all it owes.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (owed_glyphs.size() != 0) @(posedge clk);
  endtask

  // Result checker: every accepted character is compared with the oldest
  // owed one. Handshake signals are read at the edge, before any update.
  always @(posedge clk) begin : check_output
    glyph_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_glyphs.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("tb: unexpected character %h last %b taken %b",
                   out_tdata, out_tlast, out_tuser[0]);
        mismatches++;
      end else begin
        want = owed_glyphs.pop_front();
        if (want.chr !== out_tdata || want.last !== out_tlast ||
            want.taken !== out_tuser[0]) begin
          if (mismatches < MAX_REPORTS)
            $display("tb: mismatch, expected char %h last %b taken %b, got %h %b %b",
                     want.chr, want.last, want.taken, out_tdata, out_tlast,
                     out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Receiver readiness. Normally it stalls at random; on request it holds off
  // for a long, fixed stretch so that the engine backs up into its input.
  initial begin : drive_ready
    int unsigned stall;
    stall = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (rx_stalls_on && $urandom_range(99) < 30) stall = 1 + idle_len();
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("tb: failure");
    $finish;
  end

  // Main sequence: reset, directed table, random format strings, drain.
  initial begin : stimulus
    int unsigned sent;
    int unsigned next_mode_at;
    int unsigned r;
    row_t        row;
    logic [WORD_W-1:0] w;
    sent = 0;
    next_mode_at = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    // Let every result of the table come out before random traffic starts.
    drain();

    row = '0;
    while (sent < RANDOM_ITEMS) begin
      // Idling on each side is switched per stretch, so some stretches run
      // back to back and others are full of gaps.
      if (sent >= next_mode_at) begin
        tx_gaps_on   = ($urandom_range(3) != 0);
        rx_stalls_on = ($urandom_range(3) != 0);
        next_mode_at = sent + 40;
      end
      // The receiver goes quiet while items keep coming without gaps.
      if (sent >= 120 && sent < 122) begin
        hold_off_req = 1'b1;
        tx_gaps_on   = 1'b0;
      end
      // Near item 200, the sender stops until the engine has caught up completely.
      if (sent >= 200 && sent < 202) drain();

      case ($urandom_range(3))
        0:       w = border_args[$urandom_range(13)];
        1:       w = 16'($urandom_range(99));
        2:       w = 16'(-$urandom_range(100, 1));
        default: w = 16'($urandom_range(16'hFFFF));
      endcase

      r = $urandom_range(99);
      if (r < 60) begin
        // A whole conversion: percent sign, then the conversion character.
        row.ch  = CH_PCT;
        row.arg = 16'($urandom_range(16'hFFFF));
        send_item(row);
        case ($urandom_range(11))
          0:       row.ch = CH_PCT;
          1:       row.ch = CH_C;
          2, 3:    row.ch = CH_D;
          4:       row.ch = CH_I;
          5, 6:    row.ch = CH_U;
          7, 8:    row.ch = CH_X;
          9:       row.ch = CH_NUL;
          default: row.ch = 8'($urandom_range(255));
        endcase
        row.arg = w;
        send_item(row);
        sent += 2;
      end else begin
        // Plain text, or any byte at all as noise.
        row.ch  = (r < 85) ? 8'($urandom_range(126, 32)) : 8'($urandom_range(255));
        row.arg = w;
        send_item(row);
        sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_glyphs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
